[rtl/core/tepq_pkg.sv]
// ----------------------------------------------------------------------------
// tepq_pkg
// Shared types and defaults for the timed event priority queue.
// ----------------------------------------------------------------------------
package tepq_pkg;

  // Default sizing
  localparam int unsigned DEF_QUEUE_DEPTH = 64;
  localparam int unsigned DEF_TIME_BITS   = 32;
  localparam int unsigned DEF_HANDLE_BITS = 16;

  // Operation codes of an input item
  typedef enum logic [1:0] {
    FUNC_ADD    = 2'd0,
    FUNC_POP    = 2'd1,
    FUNC_CANCEL = 2'd2,
    FUNC_NOP    = 2'd3
  } func_e;

  // Result status codes
  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_EMPTY    = 2'd1,
    STAT_FULL     = 2'd2,
    STAT_NO_MATCH = 2'd3
  } status_e;

  // Broadcast command to every cell
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_POP
  } cell_op_e;

  // Cancel search wave, handed from cell to cell
  typedef struct packed {
    logic tok;  // wave is at this cell
    logic fnd;  // a match was removed at or left of here
  } wave_t;

  // Controller state
  typedef enum logic {
    ST_IDLE,
    ST_CANCEL
  } ctl_state_e;

endpackage

[rtl/core/tepq_cell.sv]
// ----------------------------------------------------------------------------
// tepq_cell
// One slot of the sorted queue: holds an entry, inserts, shifts and removes.
// ----------------------------------------------------------------------------
module tepq_cell import tepq_pkg::*; #(
  parameter int unsigned TIME_BITS   = DEF_TIME_BITS,
  parameter int unsigned HANDLE_BITS = DEF_HANDLE_BITS
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  cell_op_e               op_i,
  input  logic [TIME_BITS-1:0]   key_time_i,
  input  logic [HANDLE_BITS-1:0] key_handle_i,
  input  logic                   left_valid_i,
  input  logic                   left_ge_i,
  input  logic [TIME_BITS-1:0]   left_time_i,
  input  logic [HANDLE_BITS-1:0] left_handle_i,
  input  logic                   right_valid_i,
  input  logic [TIME_BITS-1:0]   right_time_i,
  input  logic [HANDLE_BITS-1:0] right_handle_i,
  input  wave_t                  wave_i,
  output logic                   valid_o,
  output logic                   ge_o,
  output logic [TIME_BITS-1:0]   time_o,
  output logic [HANDLE_BITS-1:0] handle_o,
  output wave_t                  wave_o
);

  logic                   valid_q, valid_d;
  logic [TIME_BITS-1:0]   time_q, time_d;
  logic [HANDLE_BITS-1:0] handle_q, handle_d;
  wave_t                  wave_q;
  logic                   hit;

  // New entry goes at or before this slot: slot empty or holds a later time
  assign ge_o = !valid_q || (time_q > key_time_i);

  // First matching entry seen by the cancel wave
  assign hit = wave_q.tok && !wave_q.fnd && valid_q &&
               (time_q == key_time_i) && (handle_q == key_handle_i);

  assign wave_o   = '{tok: wave_q.tok, fnd: wave_q.fnd | hit};
  assign valid_o  = valid_q;
  assign time_o   = time_q;
  assign handle_o = handle_q;

  // Next slot contents
  always_comb begin
    valid_d  = valid_q;
    time_d   = time_q;
    handle_d = handle_q;
    if (wave_q.tok && (wave_q.fnd || hit)) begin
      // removal at or left of here: close the gap
      valid_d  = right_valid_i;
      time_d   = right_time_i;
      handle_d = right_handle_i;
    end else begin
      unique case (op_i)
        CELL_INSERT: begin
          if (left_ge_i) begin
            valid_d  = left_valid_i;
            time_d   = left_time_i;
            handle_d = left_handle_i;
          end else if (ge_o) begin
            valid_d  = 1'b1;
            time_d   = key_time_i;
            handle_d = key_handle_i;
          end
        end
        CELL_POP: begin
          valid_d  = right_valid_i;
          time_d   = right_time_i;
          handle_d = right_handle_i;
        end
        default: begin
        end
      endcase
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      wave_q  <= '0;
    end else begin
      valid_q <= valid_d;
      wave_q  <= wave_i;
    end
  end

  // Entry payload
  always_ff @(posedge clk_i) begin
    time_q   <= time_d;
    handle_q <= handle_d;
  end

endmodule

[rtl/core/timed_event_priority_queue_unit.sv]
// ----------------------------------------------------------------------------
// timed_event_priority_queue_unit
// Bounded event list kept sorted by timestamp, with add, pop and cancel.
// ----------------------------------------------------------------------------
// A row of QUEUE_DEPTH slot cells keeps the entries sorted, earliest in slot 0;
// equal timestamps leave in insertion order. Add, pop and the unused code
// keep busy_o low, so such an item may be started every cycle while no cancel
// runs, and its result strobes on done_o in the following cycle. Cancel sends a
// search wave down the cell row one slot per cycle and holds busy_o high until
// the wave leaves the last slot; busy_o then falls as its result strobes on
// done_o. Results are shown for one cycle only; the receiver must
// take them as they come.
module timed_event_priority_queue_unit import tepq_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = DEF_QUEUE_DEPTH,
  parameter int unsigned TIME_BITS   = DEF_TIME_BITS,
  parameter int unsigned HANDLE_BITS = DEF_HANDLE_BITS,
  localparam int unsigned CNT_W      = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  output logic                   busy_o,
  input  logic [1:0]             func_i,
  input  logic [TIME_BITS-1:0]   event_time_i,
  input  logic [HANDLE_BITS-1:0] event_handle_i,
  output logic                   done_o,
  output logic [1:0]             status_o,
  output logic [TIME_BITS-1:0]   out_time_o,
  output logic [HANDLE_BITS-1:0] out_handle_o,
  output logic [CNT_W-1:0]       entry_count_o
);

  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

  ctl_state_e             state_q, state_d;
  logic [CNT_W-1:0]       count_q, count_d;
  logic [TIME_BITS-1:0]   key_time_q, key_time;
  logic [HANDLE_BITS-1:0] key_handle_q, key_handle;
  logic                   done_q, done_d;
  status_e                status_q, status_d;
  logic [TIME_BITS-1:0]   out_time_q, out_time_d;
  logic [HANDLE_BITS-1:0] out_handle_q, out_handle_d;
  logic [CNT_W-1:0]       cnt_out_q, cnt_out_d;
  cell_op_e               op;
  logic                   accept;
  func_e                  func;

  logic [QUEUE_DEPTH-1:0] cell_valid;
  logic [QUEUE_DEPTH-1:0] cell_ge;
  logic [TIME_BITS-1:0]   cell_time   [QUEUE_DEPTH];
  logic [HANDLE_BITS-1:0] cell_handle [QUEUE_DEPTH];
  wave_t                  wave_chain  [QUEUE_DEPTH+1];

  assign busy_o = (state_q == ST_CANCEL);
  assign accept = start_i && !busy_o;
  assign func   = func_e'(func_i);

  // Key: live input for add, held copy while the cancel wave runs
  assign key_time   = busy_o ? key_time_q : event_time_i;
  assign key_handle = busy_o ? key_handle_q : event_handle_i;

  // Launch the cancel wave into slot 0
  assign wave_chain[0] = '{tok: accept && (func == FUNC_CANCEL), fnd: 1'b0};

  // Slot cells
  for (genvar k = 0; k < QUEUE_DEPTH; k++) begin : g_cell
    logic                   l_valid, l_ge, r_valid;
    logic [TIME_BITS-1:0]   l_time, r_time;
    logic [HANDLE_BITS-1:0] l_handle, r_handle;

    if (k == 0) begin : g_first
      assign l_valid  = 1'b0;
      assign l_ge     = 1'b0;
      assign l_time   = '0;
      assign l_handle = '0;
    end else begin : g_mid_l
      assign l_valid  = cell_valid[k-1];
      assign l_ge     = cell_ge[k-1];
      assign l_time   = cell_time[k-1];
      assign l_handle = cell_handle[k-1];
    end

    if (k == QUEUE_DEPTH - 1) begin : g_last
      assign r_valid  = 1'b0;
      assign r_time   = '0;
      assign r_handle = '0;
    end else begin : g_mid_r
      assign r_valid  = cell_valid[k+1];
      assign r_time   = cell_time[k+1];
      assign r_handle = cell_handle[k+1];
    end

    tepq_cell #(
      .TIME_BITS   (TIME_BITS),
      .HANDLE_BITS (HANDLE_BITS)
    ) u_cell (
      .clk_i          (clk_i),
      .rst_ni         (rst_ni),
      .op_i           (op),
      .key_time_i     (key_time),
      .key_handle_i   (key_handle),
      .left_valid_i   (l_valid),
      .left_ge_i      (l_ge),
      .left_time_i    (l_time),
      .left_handle_i  (l_handle),
      .right_valid_i  (r_valid),
      .right_time_i   (r_time),
      .right_handle_i (r_handle),
      .wave_i         (wave_chain[k]),
      .valid_o        (cell_valid[k]),
      .ge_o           (cell_ge[k]),
      .time_o         (cell_time[k]),
      .handle_o       (cell_handle[k]),
      .wave_o         (wave_chain[k+1])
    );
  end

  // Next state, cell command and result
  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    op           = CELL_HOLD;
    done_d       = 1'b0;
    status_d     = STAT_OK;
    out_time_d   = '0;
    out_handle_d = '0;
    cnt_out_d    = cnt_out_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          done_d    = 1'b1;
          cnt_out_d = count_q;
          unique case (func)
            FUNC_ADD: begin
              if (count_q == FULL_CNT) begin
                status_d = STAT_FULL;
              end else begin
                op        = CELL_INSERT;
                count_d   = count_q + 1'b1;
                cnt_out_d = count_d;
              end
            end
            FUNC_POP: begin
              if (count_q == '0) begin
                status_d = STAT_EMPTY;
              end else begin
                op           = CELL_POP;
                out_time_d   = cell_time[0];
                out_handle_d = cell_handle[0];
                count_d      = count_q - 1'b1;
                cnt_out_d    = count_d;
              end
            end
            FUNC_CANCEL: begin
              done_d  = 1'b0;
              state_d = ST_CANCEL;
            end
            FUNC_NOP: begin
            end
          endcase
        end
      end
      ST_CANCEL: begin
        // wave leaves the last slot
        if (wave_chain[QUEUE_DEPTH].tok) begin
          state_d   = ST_IDLE;
          done_d    = 1'b1;
          count_d   = count_q - CNT_W'(wave_chain[QUEUE_DEPTH].fnd);
          cnt_out_d = count_d;
          status_d  = wave_chain[QUEUE_DEPTH].fnd ? STAT_OK : STAT_NO_MATCH;
        end
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      done_q  <= done_d;
    end
  end

  // Result and key payload
  always_ff @(posedge clk_i) begin
    status_q     <= status_d;
    out_time_q   <= out_time_d;
    out_handle_q <= out_handle_d;
    cnt_out_q    <= cnt_out_d;
    if (accept) begin
      key_time_q   <= event_time_i;
      key_handle_q <= event_handle_i;
    end
  end

  assign done_o        = done_q;
  assign status_o      = status_q;
  assign out_time_o    = out_time_q;
  assign out_handle_o  = out_handle_q;
  assign entry_count_o = cnt_out_q;

  // Checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FULL_CNT)
    else $error("entry count beyond queue depth");

  a_valid_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> ($countones(cell_valid) == 32'(count_q)))
    else $error("occupied slots disagree with entry count");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o == STAT_FULL)) |-> (entry_count_o == FULL_CNT))
    else $error("full status with room left");

  a_cancel_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_o && !wave_chain[QUEUE_DEPTH].tok) |=> busy_o && !done_o)
    else $error("cancel ended before the wave left the last slot");

endmodule
